### rtl/oml_pkg.sv
// ----------------------------------------------------------------------------
// oml_pkg
// Shared types, character codes and name tables for the order line checker.
// ----------------------------------------------------------------------------
package oml_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned NTYPES  = 2;
  localparam int unsigned NKEYS   = 4;
  localparam int unsigned NAME_D  = 8;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BAR     = 8'd124;
  localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'd61;
  localparam logic [POS_W-1:0]  POS_SAT    = 4'd9;

  typedef enum logic [1:0] {
    TYPE_NONE   = 2'd0,
    TYPE_ORDER  = 2'd1,
    TYPE_CANCEL = 2'd2
  } type_code_t;

  typedef enum logic [CODE_W-1:0] {
    RESP_ACK_RECEIVED  = 3'd0,
    RESP_ACK_CANCELLED = 3'd1,
    RESP_MISSING_FIELD = 3'd2,
    RESP_MISSING_ID    = 3'd3,
    RESP_UNKNOWN_TYPE  = 3'd4,
    RESP_PARSE_FAILED  = 3'd5
  } resp_code_t;

  typedef struct packed {
    logic       valid;
    resp_code_t code;
  } res_t;

  localparam logic [CHAR_W-1:0] TYPE_CHARS [NTYPES][NAME_D] = '{
    '{"O", "R", "D", "E", "R", 8'h00, 8'h00, 8'h00},
    '{"C", "A", "N", "C", "E", "L", 8'h00, 8'h00}
  };
  localparam logic [POS_W-1:0] TYPE_LENS [NTYPES] = '{4'd5, 4'd6};

  localparam logic [CHAR_W-1:0] KEY_CHARS [NKEYS][NAME_D] = '{
    '{"S", "I", "D", "E", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"Q", "T", "Y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "R", "I", "C", "E", 8'h00, 8'h00, 8'h00},
    '{"O", "R", "D", "E", "R", "_", "I", "D"}
  };
  localparam logic [POS_W-1:0] KEY_LENS [NKEYS] = '{4'd4, 4'd3, 4'd5, 4'd8};

endpackage

### rtl/oml_line_state.sv
// ----------------------------------------------------------------------------
// oml_line_state
// Per-byte update of the line parse flags; emits a response at each newline.
// ----------------------------------------------------------------------------
module oml_line_state
  import oml_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [CHAR_W-1:0] char_in,
  output res_t              res
);

  logic              in_type_r, in_type_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [NTYPES-1:0] type_cand_r, type_cand_nxt;
  logic [NKEYS-1:0]  key_cand_r, key_cand_nxt;
  logic              eq_seen_r, eq_seen_nxt;
  logic              nonempty_r, nonempty_nxt;
  type_code_t        type_res_r, type_res_nxt;
  logic [NKEYS-1:0]  keys_r, keys_nxt;
  logic              pf_r, pf_nxt;

  type_code_t        fin_type;
  logic [NKEYS-1:0]  fin_keys;
  logic [NTYPES-1:0] type_adv;
  logic [NKEYS-1:0]  key_adv;
  logic [POS_W-1:0]  pos_adv;
  logic              pf_end;
  type_code_t        type_end;
  resp_code_t        code;

  always_comb begin
    fin_type = TYPE_NONE;
    if (type_cand_r[0] && pos_r == TYPE_LENS[0]) begin
      fin_type = TYPE_ORDER;
    end else if (type_cand_r[1] && pos_r == TYPE_LENS[1]) begin
      fin_type = TYPE_CANCEL;
    end
    for (int i = 0; i < NKEYS; i++) begin
      fin_keys[i] = key_cand_r[i] && (pos_r == KEY_LENS[i]);
    end
    for (int i = 0; i < NTYPES; i++) begin
      type_adv[i] = type_cand_r[i] && (pos_r < TYPE_LENS[i]) &&
                    (TYPE_CHARS[i][pos_r[2:0]] == char_in);
    end
    for (int i = 0; i < NKEYS; i++) begin
      key_adv[i] = key_cand_r[i] && (pos_r < KEY_LENS[i]) &&
                   (KEY_CHARS[i][pos_r[2:0]] == char_in);
    end
    pos_adv = (pos_r < POS_SAT) ? pos_r + 4'd1 : pos_r;
  end

  always_comb begin
    pf_end   = pf_r;
    type_end = type_res_r;
    if (in_type_r) begin
      if (!nonempty_r) pf_end = 1'b1;
      else type_end = fin_type;
    end else if (nonempty_r && !eq_seen_r) begin
      pf_end = 1'b1;
    end
    if (pf_end) begin
      code = RESP_PARSE_FAILED;
    end else if (type_end == TYPE_ORDER) begin
      code = (keys_r[2:0] == 3'b111) ? RESP_ACK_RECEIVED : RESP_MISSING_FIELD;
    end else if (type_end == TYPE_CANCEL) begin
      code = keys_r[3] ? RESP_ACK_CANCELLED : RESP_MISSING_ID;
    end else begin
      code = RESP_UNKNOWN_TYPE;
    end
    res.valid = acc && (char_in == CH_NEWLINE);
    res.code  = code;
  end

  always_comb begin
    in_type_nxt   = in_type_r;
    pos_nxt       = pos_r;
    type_cand_nxt = type_cand_r;
    key_cand_nxt  = key_cand_r;
    eq_seen_nxt   = eq_seen_r;
    nonempty_nxt  = nonempty_r;
    type_res_nxt  = type_res_r;
    keys_nxt      = keys_r;
    pf_nxt        = pf_r;
    if (acc) begin
      if (char_in == CH_NEWLINE || char_in == CH_BAR) begin
        if (char_in == CH_NEWLINE) begin
          in_type_nxt  = 1'b1;
          type_res_nxt = TYPE_NONE;
          keys_nxt     = '0;
          pf_nxt       = 1'b0;
        end else if (in_type_r) begin
          type_res_nxt = fin_type;
          in_type_nxt  = 1'b0;
        end else if (!eq_seen_r) begin
          pf_nxt = 1'b1;
        end
        pos_nxt       = '0;
        type_cand_nxt = '1;
        key_cand_nxt  = '1;
        eq_seen_nxt   = 1'b0;
        nonempty_nxt  = 1'b0;
      end else begin
        nonempty_nxt = 1'b1;
        if (in_type_r) begin
          type_cand_nxt = type_adv;
          pos_nxt       = pos_adv;
        end else if (!eq_seen_r) begin
          if (char_in == CH_EQUALS) begin
            keys_nxt    = keys_r | fin_keys;
            eq_seen_nxt = 1'b1;
          end else begin
            key_cand_nxt = key_adv;
            pos_nxt      = pos_adv;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_type_r   <= 1'b1;
      pos_r       <= '0;
      type_cand_r <= '1;
      key_cand_r  <= '1;
      eq_seen_r   <= 1'b0;
      nonempty_r  <= 1'b0;
      type_res_r  <= TYPE_NONE;
      keys_r      <= '0;
      pf_r        <= 1'b0;
    end else begin
      in_type_r   <= in_type_nxt;
      pos_r       <= pos_nxt;
      type_cand_r <= type_cand_nxt;
      key_cand_r  <= key_cand_nxt;
      eq_seen_r   <= eq_seen_nxt;
      nonempty_r  <= nonempty_nxt;
      type_res_r  <= type_res_nxt;
      keys_r      <= keys_nxt;
      pf_r        <= pf_nxt;
    end
  end

endmodule

### rtl/oml_out_buf.sv
// ----------------------------------------------------------------------------
// oml_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module oml_out_buf
  import oml_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       push,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output resp_code_t out_code
);

  logic       main_v_r, main_v_nxt;
  logic       skid_v_r, skid_v_nxt;
  resp_code_t main_r, main_nxt;
  resp_code_t skid_r, skid_nxt;
  logic       pop;

  assign pop       = main_v_r && out_ready;
  assign space     = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_code  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push.valid) begin
      if (!main_v_r || pop) begin
        main_nxt   = push.code;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push.code;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### rtl/order_message_line_checker.sv
// ----------------------------------------------------------------------------
// order_message_line_checker
// Checks TYPE|KEY=VALUE|... text lines byte by byte, one response per line.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_char_in carries one byte per item.
// Each byte updates the line flags in the cycle it is accepted; byte 10
// (newline) closes the line and produces one item on the result channel
// out_valid/out_ready/out_response_code. Other bytes produce nothing.
// Latency: the response is on the output the cycle after the newline is
// accepted when the output register is free or taken in that same cycle;
// otherwise it waits in the skid register behind the earlier response.
// Throughput: one byte per cycle while in_ready is high; the flags update on each accepted byte.
// The result side has an output register and a skid register, so input
// keeps flowing while one response waits; in_ready drops only when both
// hold a response, and returns the cycle after the receiver takes one.
// Reset (rst_n low, synchronous) clears the line state and empties both
// result registers; in_ready is high the cycle after reset is released.
// ----------------------------------------------------------------------------
module order_message_line_checker
  import oml_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] in_char_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] out_response_code
);

  res_t       res;
  logic       acc;
  resp_code_t code;

  assign acc               = in_valid && in_ready;
  assign out_response_code = code;

  oml_line_state u_line_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .char_in (in_char_in),
    .res     (res)
  );

  oml_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_code  (code)
  );

endmodule

### rtl/oml_checker.sv
// ----------------------------------------------------------------------------
// oml_checker
// Port-level checks for the order line checker, bound to the top level.
// ----------------------------------------------------------------------------
module oml_checker
  import oml_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CHAR_W-1:0] in_char_in,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] out_response_code
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("result not empty or input not ready after reset");

  a_newline_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_char_in == CH_NEWLINE) |=> out_valid)
    else $error("newline accepted without a following result");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_response_code <= RESP_PARSE_FAILED))
    else $error("response code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_response_code)))
    else $error("stalled result item changed");

endmodule

bind order_message_line_checker oml_checker u_oml_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_char_in        (in_char_in),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_response_code (out_response_code)
);
